/* rtl/slmd_pkg.sv */
// Shared constants and types for the sorted list merge block.
`default_nettype none
package slmd_pkg;
  localparam int MAX_LEN      = 32;
  localparam int ADDR_W       = $clog2(MAX_LEN);
  localparam int CNT_W        = $clog2(MAX_LEN + 1);
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 2;
  localparam int CAP_W        = 6;
  localparam int RESULT_LIMIT = 32;

  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MERGE       = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
  } list_ctl_t;
endpackage
`default_nettype wire

/* rtl/slmd_list_store.sv */
// One list: value memory with registered read and its fill count.
`default_nettype none
module slmd_list_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire slmd_pkg::list_ctl_t       ctl,
  input  wire logic [slmd_pkg::DATA_W-1:0] wr_data,
  input  wire logic [slmd_pkg::CNT_W-1:0]  rd_idx,
  output logic      [slmd_pkg::DATA_W-1:0] rd_data,
  output logic      [slmd_pkg::CNT_W-1:0]  count
);
  import slmd_pkg::*;

  logic [DATA_W-1:0] mem [MAX_LEN];
  logic              not_full;

  assign not_full = count < CNT_W'(MAX_LEN);

  always_ff @(posedge clk) begin
    if (ctl.load && not_full) begin
      mem[count[ADDR_W-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.load && not_full) begin
      count <= count + CNT_W'(1);
    end
  end
endmodule
`default_nettype wire

/* rtl/sorted_list_merge_dedup.sv */
// Top level: two-list loader and de-duplicating ascending merge.
//
// Words with tuser 0 or 1 append tdata to the first or second list (up to
// 32 entries each, further loads dropped) and are taken one per cycle while
// no merge runs. A word with tuser 2 starts a merge: once it is taken, the
// block enters its merge state and emits one merged word per cycle unless
// the output stalls, equal heads once, up to the configured capacity (0 reads
// as 1, above 32 as 32); tlast marks the last word, tuser[1] flags a cut run
// and tuser[0] an empty run (one word, data 0). Both lists are then cleared.
// The list memories are read through a register addressed by the next read
// index, and no new word is taken until the last one is registered. tuser 3
// is taken and ignored.
`default_nettype none
module sorted_list_merge_dedup (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [slmd_pkg::CAP_W-1:0]    cfg_wdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [slmd_pkg::DATA_W-1:0]   s_axis_tdata,  // item_value
  input  wire logic [slmd_pkg::MODE_W-1:0]   s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [slmd_pkg::DATA_W-1:0]   m_axis_tdata,  // merged_value
  output logic                               m_axis_tlast,  // last
  output logic      [1:0]                    m_axis_tuser   // empty_res, truncated
);
  import slmd_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_MERGE = 1'b1;

  logic              state;
  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  i1, i2, i1_next, i2_next, i1_adv, i2_adv;
  logic [CAP_W-1:0]  n, n_inc;
  logic [DATA_W-1:0] head1, head2, val;
  logic [CNT_W-1:0]  cnt1, cnt2;
  logic              has1, has2, take1, take2, still, last_w, step, s_fire;
  list_ctl_t         ctl1, ctl2;

  logic              out_valid, out_last, out_empty, out_trunc;
  logic [DATA_W-1:0] out_data;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_W'(RESULT_LIMIT)) begin
      cap_eff = CAP_W'(RESULT_LIMIT);
    end else begin
      cap_eff = capacity;
    end
  end

  always_comb begin
    has1  = i1 < cnt1;
    has2  = i2 < cnt2;
    take1 = 1'b0;
    take2 = 1'b0;
    if (has1 && has2) begin
      if (head1 < head2) begin
        take1 = 1'b1;
      end else if (head2 < head1) begin
        take2 = 1'b1;
      end else begin
        take1 = 1'b1;
        take2 = 1'b1;
      end
    end else if (has1) begin
      take1 = 1'b1;
    end else if (has2) begin
      take2 = 1'b1;
    end
    val    = take1 ? head1 : (take2 ? head2 : '0);
    i1_adv = i1 + CNT_W'(take1);
    i2_adv = i2 + CNT_W'(take2);
    still  = (i1_adv < cnt1) || (i2_adv < cnt2);
    n_inc  = n + CAP_W'(1);
    last_w = !still || (n_inc == cap_eff);
  end

  assign step = (state == ST_MERGE) && (!out_valid || m_axis_tready);

  always_comb begin
    if (state == ST_IDLE) begin
      i1_next = '0;
      i2_next = '0;
    end else if (step) begin
      i1_next = i1_adv;
      i2_next = i2_adv;
    end else begin
      i1_next = i1;
      i2_next = i2;
    end
  end

  assign ctl1.load  = s_fire && (s_axis_tuser == MODE_LOAD_FIRST);
  assign ctl2.load  = s_fire && (s_axis_tuser == MODE_LOAD_SECOND);
  assign ctl1.clear = step && last_w;
  assign ctl2.clear = step && last_w;

  slmd_list_store u_first (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl1),
    .wr_data (s_axis_tdata),
    .rd_idx  (i1_next),
    .rd_data (head1),
    .count   (cnt1)
  );

  slmd_list_store u_second (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl2),
    .wr_data (s_axis_tdata),
    .rd_idx  (i2_next),
    .rd_data (head2),
    .count   (cnt2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(RESULT_LIMIT);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i1    <= '0;
      i2    <= '0;
      n     <= '0;
    end else begin
      i1 <= i1_next;
      i2 <= i2_next;
      unique case (state)
        ST_IDLE: begin
          n <= '0;
          if (s_fire && (s_axis_tuser == MODE_MERGE)) begin
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          if (step) begin
            n <= n_inc;
            if (last_w) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data  <= val;
      out_last  <= last_w;
      out_empty <= !has1 && !has2;
      out_trunc <= last_w && still;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = {out_trunc, out_empty};
endmodule
`default_nettype wire

/* rtl/slmd_checker.sv */
// Port-level checks for the sorted list merge block, bound to the top level.
`default_nettype none
module slmd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [1:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped under stall");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tuser[1]
      && (m_axis_tdata == 32'd0))
    else $error("empty word malformed");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("cut flag off the last word");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken mid merge");
endmodule

bind sorted_list_merge_dedup slmd_checker u_slmd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
